/* src/top_k_frequent_values_unit_assert.svh */
// ----------------------------------------------------------------------------
// top_k_frequent_values_unit_assert.svh
// assertion macros for the top-k frequency counter, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef TOP_K_FREQUENT_VALUES_UNIT_ASSERT_SVH
`define TOP_K_FREQUENT_VALUES_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define TKFV_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`define TKFV_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define TKFV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define TKFV_ASSERT_ALWAYS(label, clk, rst, cond)
`define TKFV_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TKFV_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/tkfv_pkg.sv */
// ----------------------------------------------------------------------------
// tkfv_pkg
// shared types and constants of the top-k frequency counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tkfv_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int VALUE_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int VALUE_PORT_W = 16;
  localparam int COUNT_PORT_W = 16;
  localparam int TOP_W        = 7;
  localparam int WIDE_W       = 48;

  typedef struct packed {
    logic valid;
    logic set_end;
  } head_t;

  typedef enum logic [1:0] {
    S_LOOK,
    S_UPD,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

/* src/tkfv_front.sv */
// ----------------------------------------------------------------------------
// tkfv_front
// input side: masks each value and holds items in a two-entry queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tkfv_front #(
  parameter int VALUE_BITS = tkfv_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tkfv_pkg::VALUE_PORT_W-1:0] value,
  input  logic                              set_end,
  output tkfv_pkg::head_t                   head,
  output logic [VALUE_BITS-1:0]             head_value,
  input  logic                              pop
);
  import tkfv_pkg::*;

  logic [VALUE_BITS-1:0] slot_value [2];
  logic                  slot_end   [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            fill;
  logic [WIDE_W-1:0]     value_wide;
  logic                  push;

  assign value_wide = WIDE_W'(value);
  assign in_ready   = (fill != 2'd2);
  assign push       = in_valid && in_ready;

  assign head.valid   = (fill != 2'd0);
  assign head.set_end = slot_end[rd_ptr];
  assign head_value   = slot_value[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_value[wr_ptr] <= value_wide[VALUE_BITS-1:0];
      slot_end[wr_ptr]   <= set_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

/* src/tkfv_engine.sv */
// ----------------------------------------------------------------------------
// tkfv_engine
// tag table with counts, count update, and repeated max scan for reporting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "top_k_frequent_values_unit_assert.svh"

module tkfv_engine #(
  parameter int TABLE_DEPTH = tkfv_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_BITS  = tkfv_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS  = tkfv_pkg::COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tkfv_pkg::head_t                        head,
  input  logic [VALUE_BITS-1:0]                  head_value,
  output logic                                   pop,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]       limit,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [tkfv_pkg::VALUE_PORT_W-1:0]      top_value,
  output logic [tkfv_pkg::COUNT_PORT_W-1:0]      occurrences,
  output logic                                   table_overflow,
  output logic                                   final_result
);
  import tkfv_pkg::*;

  localparam int TW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int EW = VALUE_BITS + COUNT_BITS;

  state_t state;
  state_t state_next;

  // tag cells, one compare each
  logic [VALUE_BITS-1:0] cam [TABLE_DEPTH];
  // value and count pairs
  logic [EW-1:0]         ram [TABLE_DEPTH];
  logic [EW-1:0]         rd_data;

  logic [TW-1:0]         total;
  logic                  overflow;

  logic                  hit_any;
  logic [IW-1:0]         hit_idx;
  logic                  hit_r;
  logic [IW-1:0]         hit_idx_r;

  logic [TW-1:0]         scan_idx;
  logic                  pend;
  logic [IW-1:0]         pend_idx;
  logic [TABLE_DEPTH-1:0] taken;
  logic                  best_valid;
  logic [VALUE_BITS-1:0] best_val;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [IW-1:0]         best_idx;
  logic [IW-1:0]         round;
  logic [TW-1:0]         emit_num;
  logic                  last_round;

  logic                  rd_en_scan;
  logic [IW-1:0]         rd_addr;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;
  logic                  cam_we;
  logic                  out_load;
  logic                  table_full;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [VALUE_BITS-1:0] rd_val;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  better;
  logic [WIDE_W-1:0]     val_wide;
  logic [WIDE_W-1:0]     cnt_wide;

  assign rd_cnt     = rd_data[COUNT_BITS-1:0];
  assign rd_val     = rd_data[EW-1:COUNT_BITS];
  assign cnt_inc    = (rd_cnt == {COUNT_BITS{1'b1}}) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign table_full = (total == TW'(TABLE_DEPTH));
  assign emit_num   = (limit < total) ? limit : total;
  assign last_round = ((TW'(round) + TW'(1)) == emit_num);
  assign better     = pend && !taken[pend_idx] && (!best_valid || rd_cnt > best_cnt);
  assign val_wide   = WIDE_W'(best_val);
  assign cnt_wide   = WIDE_W'(best_cnt);

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if ((TW'(i) < total) && (cam[i] == head_value)) begin
        hit_any = 1'b1;
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOOK: begin
        if (head.valid) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        state_next = head.set_end ? S_SCAN : S_LOOK;
      end
      S_SCAN: begin
        if (!rd_en_scan && !pend) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_next = last_round ? S_LOOK : S_SCAN;
        end
      end
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    rd_en_scan = 1'b0;
    rd_addr    = hit_idx;
    wr_en      = 1'b0;
    wr_addr    = hit_idx_r;
    wr_data    = {head_value, cnt_inc};
    cam_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_LOOK: begin
        rd_addr = hit_idx;
      end
      S_UPD: begin
        pop = 1'b1;
        if (hit_r) begin
          wr_en = 1'b1;
        end else if (!table_full) begin
          wr_en   = 1'b1;
          cam_we  = 1'b1;
          wr_addr = total[IW-1:0];
          wr_data = {head_value, COUNT_BITS'(1)};
        end
      end
      S_SCAN: begin
        rd_en_scan = (scan_idx < total);
        rd_addr    = scan_idx[IW-1:0];
      end
      S_EMIT: begin
        out_load = !out_valid || out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
    rd_data <= ram[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cam_we) begin
      cam[wr_addr] <= head_value;
    end
  end

  // lookup and scan bookkeeping
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      hit_r     <= hit_any;
      hit_idx_r <= hit_idx;
    end
    if (state == S_UPD) begin
      taken <= '0;
      round <= '0;
    end
    if (rd_en_scan) begin
      pend_idx <= scan_idx[IW-1:0];
    end
    if (better) begin
      best_val <= rd_val;
      best_cnt <= rd_cnt;
      best_idx <= pend_idx;
    end
    if (out_load) begin
      taken[best_idx] <= 1'b1;
      round           <= round + IW'(1);
      top_value       <= val_wide[VALUE_PORT_W-1:0];
      occurrences     <= cnt_wide[COUNT_PORT_W-1:0];
      table_overflow  <= overflow;
      final_result    <= last_round;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOOK;
      total      <= '0;
      overflow   <= 1'b0;
      scan_idx   <= '0;
      pend       <= 1'b0;
      best_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= rd_en_scan;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOOK: begin
        end
        S_UPD: begin
          scan_idx   <= '0;
          best_valid <= 1'b0;
          if (!hit_r) begin
            if (!table_full) begin
              total <= total + TW'(1);
            end else begin
              overflow <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (rd_en_scan) begin
            scan_idx <= scan_idx + TW'(1);
          end
          if (better) begin
            best_valid <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            scan_idx   <= '0;
            best_valid <= 1'b0;
            if (last_round) begin
              total    <= '0;
              overflow <= 1'b0;
            end
          end
        end
      endcase
    end
  end

  `TKFV_ASSERT_ALWAYS(a_total_bound, clk, rst, total <= TW'(TABLE_DEPTH))
  `TKFV_ASSERT_IMPLIES(a_overflow_full, clk, rst, overflow, table_full)
  `TKFV_ASSERT_IMPLIES(a_pop_in_update, clk, rst, pop, state == S_UPD && head.valid)
  `TKFV_ASSERT_IMPLIES(a_emit_has_best, clk, rst, out_load, best_valid)
  `TKFV_ASSERT_NEXT(a_final_clears, clk, rst, out_load && last_round, total == '0 && !overflow)

endmodule

/* src/top_k_frequent_values_unit.sv */
// ----------------------------------------------------------------------------
// top_k_frequent_values_unit
// counts distinct values of a set and reports the most frequent at set end
// ----------------------------------------------------------------------------
//  channel  signals                                          direction
//  cfg      cfg_valid cfg_ready cfg_data                     write, top_count
//  in       in_valid in_ready value set_end                  item in
//  out      out_valid out_ready top_value occurrences
//           table_overflow final_result                      result out
//
//  each item goes through tag compare with count read, then count write
//  at set end each reported value takes one scan of the count memory
//  over the n distinct values, so k scans per set
//  reset clears control state only, no clearing pass over the tables
//  a two-entry input queue and an output register decouple both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module top_k_frequent_values_unit #(
  parameter int TABLE_DEPTH = tkfv_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_BITS  = tkfv_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS  = tkfv_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tkfv_pkg::TOP_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tkfv_pkg::VALUE_PORT_W-1:0] value,
  input  logic                              set_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tkfv_pkg::VALUE_PORT_W-1:0] top_value,
  output logic [tkfv_pkg::COUNT_PORT_W-1:0] occurrences,
  output logic                              table_overflow,
  output logic                              final_result
);
  import tkfv_pkg::*;

  localparam int TW = $clog2(TABLE_DEPTH + 1);

  logic [TOP_W-1:0]      top_count;
  logic [TW-1:0]         limit;
  head_t                 head;
  logic [VALUE_BITS-1:0] head_value;
  logic                  pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= TOP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      top_count <= cfg_data;
    end
  end

  always_comb begin
    priority if (top_count == '0) begin
      limit = TW'(1);
    end else if (top_count > TOP_W'(TABLE_DEPTH)) begin
      limit = TW'(TABLE_DEPTH);
    end else begin
      limit = TW'(top_count);
    end
  end

  tkfv_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .set_end    (set_end),
    .head       (head),
    .head_value (head_value),
    .pop        (pop)
  );

  tkfv_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_value     (head_value),
    .pop            (pop),
    .limit          (limit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .top_value      (top_value),
    .occurrences    (occurrences),
    .table_overflow (table_overflow),
    .final_result   (final_result)
  );

endmodule
